/* design/lkv_pkg.sv */
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CAP_W = 5;
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Register index, taken from the word address bits of paddr
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   // Decision broadcast from the controller to every cell
   typedef struct packed {
      logic              upd;
      logic              put;
      logic              hit;
      logic              evict;
      logic [RANK_W-1:0] hit_rank;
      logic [RANK_W-1:0] lru_rank;
   } ctl_type;

   // Word handed from one cell to the next along the row
   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] value;
      logic [RANK_W-1:0]        rank;
      logic                     free_seen;
   } chain_type;

   typedef struct packed {
      logic valid;
      logic match;
   } cell_stat_type;

endpackage

/* design/lkv_cell.sv */
// One cache entry: key, value, valid mark and recency rank.
module lkv_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lkv_pkg::req_type      req,
   input  lkv_pkg::ctl_type      ctl,
   input  lkv_pkg::chain_type    chain_prev,
   output lkv_pkg::chain_type    chain_next,
   output lkv_pkg::cell_stat_type stat
);

   logic                                valid_ff, valid_in;
   logic signed [lkv_pkg::DATA_W-1:0]   key_ff, key_in;
   logic signed [lkv_pkg::DATA_W-1:0]   value_ff, value_in;
   logic [lkv_pkg::RANK_W-1:0]          rank_ff, rank_in;

   logic match;
   logic lru;
   logic take_free;
   logic target;
   logic age;

   always_comb begin
      match     = valid_ff && (key_ff == req.key);
      lru       = valid_ff && (rank_ff == ctl.lru_rank);
      take_free = !valid_ff && !chain_prev.free_seen;
      if (ctl.hit) begin
         target = match;
      end else if (ctl.evict) begin
         target = lru;
      end else begin
         target = take_free;
      end
      // on a hit only entries more recent than the hit one age
      age = valid_ff && !target && (!ctl.hit || (rank_ff < ctl.hit_rank));

      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      if (ctl.upd) begin
         if (target) begin
            rank_in = '0;
            if (ctl.put) begin
               valid_in = 1'b1;
               key_in   = req.key;
               value_in = req.value;
            end
         end else if (age) begin
            rank_in = rank_ff + 1'b1;
         end
      end

      chain_next.hit       = chain_prev.hit | match;
      chain_next.value     = chain_prev.value | (match ? value_ff : '0);
      chain_next.rank      = chain_prev.rank | (match ? rank_ff : '0);
      chain_next.free_seen = chain_prev.free_seen | !valid_ff;

      stat.valid = valid_ff;
      stat.match = match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

endmodule

/* design/lru_key_value_cache.sv */
// Top level of the LRU key/value cache: control, CSR and the row of entry cells.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  request  | start in, busy out     | req_op, req_key, req_value
//  response | rsp_valid out (1 cyc)  | rsp_hit, rsp_read_value, rsp_evicted
//  csr      | psel/penable/pready    | paddr, pwrite, pwdata, prdata
//
// Each item is accepted at an edge into the compare state, in which every
// cell compares the key and the match/free/rank words ripple down the row;
// the update and the response register land at the next edge.
// busy is high for the compare cycle alone; start may come again right after.
// Reset clears all valid marks and occupancy at once; capacity returns to 16.
// The response strobe lasts one cycle and cannot be stalled.
module lru_key_value_cache (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [lkv_pkg::DATA_W-1:0]   req_key,
   input  logic signed [lkv_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic signed [lkv_pkg::DATA_W-1:0]   rsp_read_value,
   output logic                                rsp_evicted,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lkv_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   lkv_pkg::state_type               state_ff, state_in;
   lkv_pkg::req_type                 req_ff;
   logic [lkv_pkg::CAP_W-1:0]        cap_ff;
   logic [lkv_pkg::OCC_W-1:0]        occ_ff, occ_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic signed [lkv_pkg::DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic                             rsp_evicted_ff, rsp_evicted_in;

   lkv_pkg::ctl_type                 ctl;
   lkv_pkg::chain_type               chain [0:lkv_pkg::ENTRIES];
   lkv_pkg::cell_stat_type           stat [lkv_pkg::ENTRIES];
   logic [lkv_pkg::ENTRIES-1:0]      valid_vec;
   logic [lkv_pkg::ENTRIES-1:0]      match_vec;

   logic                             accept;
   logic                             work;
   logic                             csr_write;
   logic [lkv_pkg::CMP_W-1:0]        cap_ext;
   logic [lkv_pkg::CMP_W-1:0]        eff_cap;
   logic [lkv_pkg::CMP_W-1:0]        occ_ext;
   logic [lkv_pkg::OCC_W-1:0]        occ_less;

   assign accept    = start && !busy;
   assign work      = (state_ff == lkv_pkg::ST_WORK);
   assign busy      = work;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == lkv_pkg::REG_CAPACITY) ?
                      32'(cap_ff) : 32'd0;

   assign chain[0] = '0;

   for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .req        (req_ff),
         .ctl        (ctl),
         .chain_prev (chain[i]),
         .chain_next (chain[i+1]),
         .stat       (stat[i])
      );
      assign valid_vec[i] = stat[i].valid;
      assign match_vec[i] = stat[i].match;
   end

   always_comb begin
      cap_ext = lkv_pkg::CMP_W'(cap_ff);
      occ_ext = lkv_pkg::CMP_W'(occ_ff);
      if (cap_ext == '0) begin
         eff_cap = lkv_pkg::CMP_W'(1);
      end else if (cap_ext > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES)) begin
         eff_cap = lkv_pkg::CMP_W'(lkv_pkg::ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      occ_less = occ_ff - 1'b1;

      ctl.put      = (req_ff.op == lkv_pkg::OP_PUT);
      ctl.hit      = chain[lkv_pkg::ENTRIES].hit;
      ctl.hit_rank = chain[lkv_pkg::ENTRIES].rank;
      // effective capacity is at least one, so a full store always holds an entry
      ctl.evict    = ctl.put && !ctl.hit && (occ_ext >= eff_cap);
      ctl.lru_rank = lkv_pkg::RANK_W'(occ_less);
      ctl.upd      = work && (ctl.put || ctl.hit);
   end

   always_comb begin
      state_in          = state_ff;
      occ_in            = occ_ff;
      rsp_valid_in      = 1'b0;
      rsp_hit_in        = rsp_hit_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_evicted_in    = rsp_evicted_ff;
      case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lkv_pkg::ST_WORK;
            end
         end
         lkv_pkg::ST_WORK: begin
            state_in       = lkv_pkg::ST_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_hit_in     = ctl.hit;
            rsp_evicted_in = ctl.evict;
            if (ctl.put) begin
               rsp_read_value_in = '0;
            end else if (ctl.hit) begin
               rsp_read_value_in = chain[lkv_pkg::ENTRIES].value;
            end else begin
               rsp_read_value_in = lkv_pkg::MISS_VALUE;
            end
            if (ctl.put && !ctl.hit && !ctl.evict) begin
               occ_in = occ_ff + 1'b1;
            end
         end
         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         occ_ff       <= '0;
         cap_ff       <= lkv_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (paddr[2] == lkv_pkg::REG_CAPACITY)) begin
            cap_ff <= pwdata[lkv_pkg::CAP_W-1:0];
         end
      end
   end

   // hold the request word for the compare cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.op    <= req_op;
         req_ff.key   <= req_key;
         req_ff.value <= req_value;
      end
      rsp_hit_ff        <= rsp_hit_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_evicted_ff    <= rsp_evicted_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one entry matches the key");

   a_occ_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(occ_ff))
      else $error("occupancy out of step with valid marks");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= lkv_pkg::OCC_W'(lkv_pkg::ENTRIES))
      else $error("occupancy above entry count");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      work |=> rsp_valid_ff && !work)
      else $error("response strobe missing after compare cycle");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted_ff) |-> !rsp_hit_ff)
      else $error("eviction reported on a hit");

endmodule

/* tb/sv/tb_lru_key_value_cache.sv */
// Self-checking testbench for the LRU key/value cache: directed and random gets/puts.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 95;
   localparam int POOL_MAX = 32;
   localparam int QUIET_PHASE = 5;
   localparam logic [lkv_pkg::CSR_ADDR_W-1:0] CAPACITY_ADDR =
      lkv_pkg::CSR_ADDR_W'(lkv_pkg::REG_CAPACITY) << 2;

   typedef struct {
      logic                       hit;
      logic [lkv_pkg::DATA_W-1:0] read_value;
      logic                       evicted;
   } lookup_result_type;

   // Mirror of the store: keeps its own entries and recency and predicts each response.
   class lru_mirror;
      logic [lkv_pkg::DATA_W-1:0] slot_key [lkv_pkg::ENTRIES];
      logic [lkv_pkg::DATA_W-1:0] slot_data [lkv_pkg::ENTRIES];
      bit                         slot_live [lkv_pkg::ENTRIES];
      int unsigned                slot_age [lkv_pkg::ENTRIES];
      int unsigned                fill;
      int unsigned                capacity;
      lookup_result_type          pending[$];
      int                         errors;

      function new();
         foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_age[i] = 0;
         end
         fill = 0;
         capacity = lkv_pkg::CAPACITY_RESET;
         errors = 0;
      endfunction

      function void set_capacity(logic [31:0] word);
         capacity = word[lkv_pkg::CAP_W-1:0];
      endfunction

      // Make slot s most recent; live entries younger than limit age by one.
      function void touch(int s, int unsigned limit);
         foreach (slot_live[i])
            if (slot_live[i] && i != s && slot_age[i] < limit)
               slot_age[i]++;
         slot_age[s] = 0;
      endfunction

      function void note_item(logic op, logic [lkv_pkg::DATA_W-1:0] key,
                              logic [lkv_pkg::DATA_W-1:0] data);
         int                found;
         int                victim;
         int                free_slot;
         int unsigned       usable;
         lookup_result_type r;
         found = -1;
         victim = -1;
         free_slot = -1;
         foreach (slot_live[i]) begin
            if (slot_live[i] && slot_key[i] == key && found < 0)
               found = i;
            if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
               victim = i;
            if (!slot_live[i] && free_slot < 0)
               free_slot = i;
         end
         usable = (capacity == 0) ? 1 :
                  ((capacity > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : capacity);
         r.hit = (found >= 0);
         r.read_value = '0;
         r.evicted = 1'b0;
         if (op == lkv_pkg::OP_GET) begin
            if (found >= 0) begin
               r.read_value = slot_data[found];
               touch(found, slot_age[found]);
            end else begin
               r.read_value = lkv_pkg::MISS_VALUE;
            end
         end else if (found >= 0) begin
            slot_data[found] = data;
            touch(found, slot_age[found]);
         end else if ((fill >= usable && fill > 0) || free_slot < 0) begin
            // replace the least recent entry in place
            r.evicted = 1'b1;
            slot_key[victim] = key;
            slot_data[victim] = data;
            touch(victim, slot_age[victim]);
         end else begin
            slot_key[free_slot] = key;
            slot_data[free_slot] = data;
            slot_live[free_slot] = 1'b1;
            touch(free_slot, 32'hFFFF_FFFF);
            fill++;
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic hit, logic [lkv_pkg::DATA_W-1:0] read_value,
                                 logic evicted);
         lookup_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected response: hit=%0b read_value=%h evicted=%0b",
                   hit, read_value, evicted);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, hit);
            errors++;
         end
         if (read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, read_value);
            errors++;
         end
         if (evicted !== want.evicted) begin
            $error("evicted: expected %0b, actual %0b", want.evicted, evicted);
            errors++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic                              req_op = lkv_pkg::OP_GET;
   logic signed [lkv_pkg::DATA_W-1:0] req_key = '0;
   logic signed [lkv_pkg::DATA_W-1:0] req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_hit;
   logic signed [lkv_pkg::DATA_W-1:0] rsp_read_value;
   logic                              rsp_evicted;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [lkv_pkg::CSR_ADDR_W-1:0]    paddr = '0;
   logic [31:0]                       pwdata = '0;
   logic [31:0]                       prdata;
   logic                              pready;

   lru_mirror                  mirror;
   logic [lkv_pkg::DATA_W-1:0] key_pool [POOL_MAX];
   int                         pool_len;
   int                         cycles = 0;

   lru_key_value_cache dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_read_value(rsp_read_value),
      .rsp_evicted(rsp_evicted),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         mirror.check_result(rsp_hit, rsp_read_value, rsp_evicted);
   end

   // Present one word and hold it until the block takes it.
   task automatic send_item(input logic op, input logic [lkv_pkg::DATA_W-1:0] key,
                            input logic [lkv_pkg::DATA_W-1:0] data);
      @(negedge clock);
      start <= 1'b1;
      req_op <= op;
      req_key <= key;
      req_value <= data;
      do @(posedge clock); while (busy !== 1'b0);
      mirror.note_item(op, key, data);
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (mirror.pending.size() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [31:0] word);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAPACITY_ADDR;
      pwdata <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      mirror.set_capacity(word);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [lkv_pkg::DATA_W-1:0] pick_data();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [lkv_pkg::DATA_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, pool_len - 1)];
      return $urandom();
   endfunction

   function automatic int pick_gap(input bit quiet);
      if (!quiet && $urandom_range(0, 99) < 35)
         return $urandom_range(1, 4);
      return 0;
   endfunction

   initial begin
      int          cap;
      int unsigned usable;
      logic [31:0] word;
      mirror = new();
      foreach (key_pool[i])
         key_pool[i] = pick_data();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, update, miss value, fill to 16 and evict the oldest
      send_item(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_1234);
      send_item(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      for (int i = 0; i < 13; i++)
         send_item(lkv_pkg::OP_PUT, 32'(i + 1), ~32'(i));
      send_item(lkv_pkg::OP_PUT, 32'h0000_0100, 32'h0000_0005);
      send_item(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);

      // random phases: first the special capacities, the first one below the fill level
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: cap = 3;
            1: cap = 0;
            2: cap = 31;
            3: cap = 17;
            4: cap = 1;
            5: cap = 16;
            default: cap = $urandom_range(0, 31);
         endcase
         drain();
         word = ($urandom_range(0, 1) ? ($urandom() & ~32'h1F) : 32'h0) | 32'(cap);
         write_capacity(word);
         usable = (cap == 0) ? 1 :
                  ((cap > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : cap);
         pool_len = usable + $urandom_range(0, 6);
         // keep part of the old keys so hits on earlier entries still happen
         for (int i = 0; i < pool_len; i++)
            if ($urandom_range(0, 1))
               key_pool[i] = $urandom();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(logic'($urandom_range(0, 1)), pick_key(), pick_data());
            pause(pick_gap(p == QUIET_PHASE));
         end
      end

      drain();
      if (mirror.errors == 0 && mirror.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
